// ===== rtl/lsi_pkg.sv =====
// Shared types and constants for the search-and-insert stack.
`default_nettype none
package lsi_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 3;
  localparam int POS_W           = 6;
  localparam int STATUS_W        = 3;
  // Count width for the largest supported depth of 64 entries.
  localparam int CNT_MAX_W       = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_DISPLAY = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_INSERT  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INSERT,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SHOW
  } fsm_t;

  // Broadcast control seen by every cell of the chain.
  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  value;
    logic [POS_W-1:0]          pos;
    logic [CNT_MAX_W-1:0]      count;
    logic [CNT_MAX_W-1:0]      bottom;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/lsi_cell.sv =====
// One storage cell of the stack chain; cell INDEX holds the entry INDEX steps below the top.
`default_nettype none
module lsi_cell #(
  parameter int INDEX = 0
) (
  input  wire                                     clk,
  input  wire lsi_pkg::cell_ctrl_t                ctrl,
  input  wire logic signed [lsi_pkg::DATA_W-1:0]  above,
  input  wire logic signed [lsi_pkg::DATA_W-1:0]  below,
  input  wire logic signed [lsi_pkg::DATA_W-1:0]  top,
  output logic signed [lsi_pkg::DATA_W-1:0]       data,
  output logic                                    match
);
  import lsi_pkg::*;

  localparam logic [CNT_MAX_W-1:0] KIDX = CNT_MAX_W'(INDEX);

  logic signed [DATA_W-1:0] data_next;
  logic [CNT_MAX_W-1:0]     pos_ext;

  assign pos_ext = CNT_MAX_W'(ctrl.pos);

  always_comb begin
    data_next = data;
    case (ctrl.cmd)
      CELL_PUSH: begin
        data_next = (KIDX == '0) ? ctrl.value : above;
      end
      CELL_POP: begin
        data_next = below;
      end
      CELL_INSERT: begin
        if (KIDX == pos_ext) begin
          data_next = ctrl.value;
        end else if (KIDX > pos_ext) begin
          data_next = above;
        end
      end
      CELL_ROTATE: begin
        data_next = (KIDX == ctrl.bottom) ? top : below;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only occupied cells may report a hit.
  assign match = (data == ctrl.value) && (KIDX < ctrl.count);

endmodule
`default_nettype wire

// ===== rtl/lifo_stack_with_search_insert.sv =====
// Top level of the bounded stack with search and positional insert.
// Push, pop, search and insert: the item is taken and its result is registered on the same
// edge, so it is offered in the next cycle, and items follow at one per cycle while the
// result side does not stall. A display holds the block until its last entry is streamed,
// one entry per result transfer, plus any stalls on the result side; no new item is taken.
// Reset clears the entry count, the control state and the result valid flag; cell
// contents are left as they are and are never read before being written.
`default_nettype none
module lifo_stack_with_search_insert #(
  parameter int STACK_DEPTH = lsi_pkg::STACK_DEPTH_DEF
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       item_valid,
  output logic                                      item_stall,
  input  wire logic [lsi_pkg::OP_W-1:0]             op,
  input  wire logic signed [lsi_pkg::DATA_W-1:0]    value,
  input  wire logic [lsi_pkg::POS_W-1:0]            position,
  output logic                                      result_valid,
  input  wire                                       result_stall,
  output logic [lsi_pkg::STATUS_W-1:0]              status,
  output logic signed [lsi_pkg::DATA_W-1:0]         data,
  output logic [lsi_pkg::POS_W-1:0]                 steps,
  output logic                                      last
);
  import lsi_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // Control state. The count is the number of occupied cells; during a display the
  // remaining counter tells how many entries are still to be streamed.
  fsm_t             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remaining, remaining_next;

  // The chain of cells. Cell zero is always the top of the stack.
  cell_ctrl_t               ctrl;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [STACK_DEPTH];
  logic [STACK_DEPTH-1:0]   match_vec;

  // Result register loading.
  logic                     out_free;
  logic                     load;
  status_t                  status_next;
  logic signed [DATA_W-1:0] data_next;
  logic [POS_W-1:0]         steps_next;
  logic                     last_next;

  // Search hit decode.
  logic                     hit;
  logic [POS_W-1:0]         hit_idx;

  logic                     is_empty, is_full, pos_bad;

  assign ctrl.cmd    = cmd;
  assign ctrl.value  = value;
  assign ctrl.pos    = position;
  assign ctrl.count  = CNT_MAX_W'(count);
  // Index of the bottom cell, used as the wrap point while a display rotates the chain.
  assign ctrl.bottom = CNT_MAX_W'(count) - CNT_MAX_W'(1);

  genvar g;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] above_d, below_d;
      if (g == 0) begin : g_first
        assign above_d = '0;
      end else begin : g_mid_a
        assign above_d = cell_data[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_last
        assign below_d = '0;
      end else begin : g_mid_b
        assign below_d = cell_data[g+1];
      end
      lsi_cell #(
        .INDEX (g)
      ) u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .above (above_d),
        .below (below_d),
        .top   (cell_data[0]),
        .data  (cell_data[g]),
        .match (match_vec[g])
      );
    end
  endgenerate

  // The first match closest to the top wins, so scan from the bottom up and let
  // smaller indexes override.
  always_comb begin
    hit     = |match_vec;
    hit_idx = '0;
    for (int k = STACK_DEPTH - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        hit_idx = POS_W'(k);
      end
    end
  end

  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(STACK_DEPTH));
  assign pos_bad  = (CNT_MAX_W'(position) >= CNT_MAX_W'(count));

  // The result register can take a new transfer when it is empty or being drained.
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    cmd            = CELL_HOLD;
    load           = 1'b0;
    status_next    = ST_OK;
    data_next      = '0;
    steps_next     = '0;
    last_next      = 1'b1;
    item_stall     = 1'b1;
    case (state)
      FSM_IDLE: begin
        item_stall = !out_free;
        if (item_valid && out_free) begin
          case (op)
            OP_PUSH: begin
              load = 1'b1;
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                cmd        = CELL_PUSH;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP: begin
              load = 1'b1;
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                cmd        = CELL_POP;
                count_next = count - CNT_W'(1);
              end
            end
            OP_DISPLAY: begin
              if (is_empty) begin
                load        = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next     = FSM_SHOW;
                remaining_next = count;
              end
            end
            OP_SEARCH: begin
              load = 1'b1;
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else if (hit) begin
                steps_next = hit_idx;
              end else begin
                status_next = ST_NOTFOUND;
              end
            end
            OP_INSERT: begin
              load = 1'b1;
              if (pos_bad) begin
                status_next = ST_RANGE;
              end else if (is_full) begin
                status_next = ST_FULL;
              end else begin
                cmd        = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            default: begin
              // Unused operation codes are consumed without a result.
              load = 1'b0;
            end
          endcase
        end
      end
      FSM_SHOW: begin
        // Stream the top cell, then rotate so the next entry moves up to the top.
        // After count rotations the chain is back in its original order.
        if (out_free) begin
          load           = 1'b1;
          data_next      = cell_data[0];
          last_next      = (remaining == CNT_W'(1));
          cmd            = CELL_ROTATE;
          remaining_next = remaining - CNT_W'(1);
          if (last_next) begin
            state_next = FSM_IDLE;
          end
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FSM_IDLE;
      count        <= '0;
      remaining    <= '0;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      data   <= data_next;
      steps  <= steps_next;
      last   <= last_next;
    end
  end

endmodule
`default_nettype wire
